// File: hw/rtl/rtbm_pkg.sv
// Package for the route table with lowest-metric lookup.
// Holds sizes, opcodes, controller states and the channel and command structs.
// No dependencies.
package rtbm_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int ADDR_BITS     = 32;
  localparam int FIELD_BITS    = 32;
  localparam int STORE_BITS    = (ADDR_BITS < FIELD_BITS) ? ADDR_BITS : FIELD_BITS;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int METRIC_BITS   = 16;

  localparam logic [METRIC_BITS-1:0] METRIC_NONE = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FIND   = 2'd1,
    OP_DELETE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]             opcode;
    logic [FIELD_BITS-1:0]  dest_addr;
    logic [FIELD_BITS-1:0]  gateway_addr;
    logic [METRIC_BITS-1:0] route_metric;
  } req_t;

  typedef struct packed {
    logic                  status;
    logic                  route_found;
    logic [FIELD_BITS-1:0] best_gateway;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

// File: hw/rtl/route_table_best_metric.sv
// Route table with lowest-metric lookup, top level.
// Request channel: req_valid / req_stall with payload req (opcode, dest_addr,
//   gateway_addr, route_metric). Response channel: rsp_valid / rsp_stall with
//   payload rsp (status, route_found, best_gateway). A transfer happens at a
//   rising edge with valid high and stall low.
// Each request gives exactly one response. Add updates the metric of a route
//   with the same destination and gateway or fills the lowest free slot, and
//   sets status when the table is full. Find returns the lowest-metric gateway
//   for the destination, lowest slot on ties; metric 0xFFFF never matches.
//   Delete clears the lowest matching route.
// Timing: the scan reads one table slot per cycle. A request is taken, the scan
//   walks all TABLE_ENTRIES slots, then the update and the response are
//   committed and the response is registered. A new request is taken only
//   after that commit, when the controller has returned to idle. The table
//   has a single read port, stepped by the scan counter.
// The response sits in an output register; a stalled response holds, and the
//   next request may be taken and scanned meanwhile, its commit waiting until
//   the register is free.
// Synchronous reset (rst) empties the table at once; req_stall is low after it.
// Depends on rtbm_pkg, rtbm_ctrl and rtbm_datapath.
module route_table_best_metric (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  rtbm_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output rtbm_pkg::rsp_t  rsp
);
  import rtbm_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_status;

  rtbm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  rtbm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .dp_status (dp_status),
    .rsp       (rsp)
  );

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> cmd.step)
    else $error("scan did not start after request transfer");

  a_commit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp_valid || !rsp_stall))
    else $error("commit overwrote a pending response");

  a_commit_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> rsp_valid)
    else $error("commit did not raise response valid");

  a_one_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.commit}))
    else $error("more than one datapath command at once");

endmodule

// File: hw/rtl/rtbm_datapath.sv
// Datapath of the route table: entry stores, scan index, match and best-route
// trackers, and the result register. Uses rtbm_pkg; driven by rtbm_ctrl commands.
module rtbm_datapath (
  input  logic                clk,
  input  logic                rst,
  input  rtbm_pkg::req_t      req,
  input  rtbm_pkg::cmd_t      cmd,
  output rtbm_pkg::dp_status_t dp_status,
  output rtbm_pkg::rsp_t      rsp
);
  import rtbm_pkg::*;

  logic [1:0]             op;
  logic [STORE_BITS-1:0]  dest;
  logic [STORE_BITS-1:0]  gateway;
  logic [METRIC_BITS-1:0] metric;

  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [STORE_BITS-1:0]    entry_dest    [TABLE_ENTRIES];
  logic [STORE_BITS-1:0]    entry_gateway [TABLE_ENTRIES];
  logic [METRIC_BITS-1:0]   entry_metric  [TABLE_ENTRIES];

  logic [IDX_BITS-1:0]    cnt;
  logic                   match_hit;
  logic [IDX_BITS-1:0]    match_idx;
  logic                   free_hit;
  logic [IDX_BITS-1:0]    free_idx;
  logic                   found;
  logic [METRIC_BITS-1:0] low_metric;
  logic [STORE_BITS-1:0]  best_gw;

  logic                  cur_valid;
  logic                  dest_eq;
  logic                  gw_eq;
  logic                  add_new;
  logic [FIELD_BITS-1:0] gw_ext;
  rsp_t                  rsp_next;

  assign cur_valid = entry_valid[cnt];
  assign dest_eq   = entry_dest[cnt] == dest;
  assign gw_eq     = entry_gateway[cnt] == gateway;
  assign add_new   = (op == OP_ADD) && !match_hit && free_hit;
  assign dp_status.last = cnt == IDX_BITS'(TABLE_ENTRIES - 1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= req.opcode;
      dest    <= req.dest_addr[STORE_BITS-1:0];
      gateway <= req.gateway_addr[STORE_BITS-1:0];
      metric  <= req.route_metric;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cnt        <= '0;
      match_hit  <= 1'b0;
      match_idx  <= '0;
      free_hit   <= 1'b0;
      free_idx   <= '0;
      found      <= 1'b0;
      low_metric <= METRIC_NONE;
      best_gw    <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + 1'b1;
      if (cur_valid && dest_eq && gw_eq && !match_hit) begin
        match_hit <= 1'b1;
        match_idx <= cnt;
      end
      if (!cur_valid && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= cnt;
      end
      if (cur_valid && dest_eq && (entry_metric[cnt] < low_metric)) begin
        low_metric <= entry_metric[cnt];
        best_gw    <= entry_gateway[cnt];
        found      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.commit) begin
      if (add_new) begin
        entry_valid[free_idx] <= 1'b1;
      end else if ((op == OP_DELETE) && match_hit) begin
        entry_valid[match_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && (op == OP_ADD)) begin
      if (match_hit) begin
        entry_metric[match_idx] <= metric;
      end else if (free_hit) begin
        entry_dest[free_idx]    <= dest;
        entry_gateway[free_idx] <= gateway;
        entry_metric[free_idx]  <= metric;
      end
    end
  end

  always_comb begin
    gw_ext = '0;
    gw_ext[STORE_BITS-1:0] = best_gw;
    rsp_next = '0;
    case (op)
      OP_ADD: begin
        rsp_next.status = !match_hit && !free_hit;
      end
      OP_FIND: begin
        rsp_next.route_found  = found;
        rsp_next.best_gateway = gw_ext;
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

// File: hw/rtl/rtbm_ctrl.sv
// Controller of the route table: accept, scan and commit sequencing and the
// result valid flag. Uses rtbm_pkg; steers rtbm_datapath through cmd_t.
module rtbm_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  input  rtbm_pkg::dp_status_t dp_status,
  output rtbm_pkg::cmd_t       cmd
);
  import rtbm_pkg::*;

  state_t state;
  state_t state_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.step = 1'b1;
        if (dp_status.last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (cmd.commit) begin
      rsp_valid_next = 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

endmodule

// File: test/tb_top.sv
// Testbench for route_table_best_metric: directed and random add, find and delete
// transfers, checked against a shadow route table kept in a scoreboard class.
// Depends on rtbm_pkg and route_table_best_metric.
`timescale 1ns / 100ps

module tb_top;
  import rtbm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 450;
  localparam int SETTLE_CYCLES = 40;

  class route_table_shadow;
    bit                   live [TABLE_ENTRIES];
    bit [STORE_BITS-1:0]  dest [TABLE_ENTRIES];
    bit [STORE_BITS-1:0]  gate [TABLE_ENTRIES];
    bit [METRIC_BITS-1:0] cost [TABLE_ENTRIES];
    rsp_t                 expected_rsp [$];
    int                   mismatches;

    function new();
      foreach (live[i]) live[i] = 1'b0;
      mismatches = 0;
    endfunction

    function int pair_slot(bit [STORE_BITS-1:0] d, bit [STORE_BITS-1:0] g);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (live[i] && dest[i] == d && gate[i] == g) return i;
      end
      return -1;
    endfunction

    function void note_request(req_t r);
      rsp_t                 exp;
      bit [STORE_BITS-1:0]  d;
      bit [STORE_BITS-1:0]  g;
      bit [METRIC_BITS:0]   best;
      int                   slot;
      exp = '0;
      d = r.dest_addr[STORE_BITS-1:0];
      g = r.gateway_addr[STORE_BITS-1:0];
      slot = pair_slot(d, g);
      case (r.opcode)
        OP_ADD: begin
          if (slot >= 0) begin
            cost[slot] = r.route_metric;
          end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              if (!live[i] && slot < 0) slot = i;
            end
            if (slot >= 0) begin
              live[slot] = 1'b1;
              dest[slot] = d;
              gate[slot] = g;
              cost[slot] = r.route_metric;
            end else begin
              exp.status = 1'b1;
            end
          end
        end
        OP_FIND: begin
          best = {1'b0, METRIC_NONE};
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (live[i] && dest[i] == d && {1'b0, cost[i]} < best) begin
              best = {1'b0, cost[i]};
              exp.route_found = 1'b1;
              exp.best_gateway = FIELD_BITS'(gate[i]);
            end
          end
        end
        OP_DELETE: begin
          if (slot >= 0) live[slot] = 1'b0;
        end
        default: ;
      endcase
      expected_rsp.push_back(exp);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected response, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      exp = expected_rsp.pop_front();
      if (got.status !== exp.status) begin
        $display("%0t: status expected %b actual %b", $time, exp.status, got.status);
        mismatches++;
      end
      if (got.route_found !== exp.route_found) begin
        $display("%0t: route_found expected %b actual %b", $time, exp.route_found,
                 got.route_found);
        mismatches++;
      end
      if (got.best_gateway !== exp.best_gateway) begin
        $display("%0t: best_gateway expected %h actual %h", $time, exp.best_gateway,
                 got.best_gateway);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  route_table_shadow board = new();

  int stall_mode = 0;
  int stall_mode_left = 0;

  route_table_best_metric u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) board.check_response(rsp);
    if (stall_mode_left == 0) begin
      stall_mode <= $urandom_range(3);
      stall_mode_left <= $urandom_range(20, 80);
    end else begin
      stall_mode_left <= stall_mode_left - 1;
    end
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(3) == 0);
      2: rsp_stall <= ($urandom_range(3) != 0);
      default: rsp_stall <= ($urandom_range(9) == 0) ? ~rsp_stall : rsp_stall;
    endcase
  end

  task automatic send_request(input req_t r);
    req <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(r);
  endtask

  task automatic issue_route_op(input logic [1:0] op, input logic [31:0] d,
                                input logic [31:0] g, input logic [15:0] m);
    req_t r;
    r.opcode = op;
    r.dest_addr = d;
    r.gateway_addr = g;
    r.route_metric = m;
    send_request(r);
  endtask

  task automatic pause_sender(input int cycles);
    req_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  function automatic req_t random_request(input int add_pct);
    req_t        r;
    int          pick;
    logic [31:0] dest_pool [6];
    logic [31:0] gate_pool [4];
    dest_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001, 32'hC0A8_0101,
                  32'h8000_0000, 32'h7FFF_FFFF};
    gate_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_AAAA, 32'hAAAA_5555};
    pick = $urandom_range(99);
    if (pick < add_pct) r.opcode = OP_ADD;
    else if (pick < add_pct + (97 - add_pct) * 3 / 5) r.opcode = OP_FIND;
    else if (pick < 97) r.opcode = OP_DELETE;
    else r.opcode = OP_UNUSED;
    if ($urandom_range(9) == 0 || r.opcode == OP_UNUSED) begin
      r.dest_addr = $urandom;
      r.gateway_addr = $urandom;
    end else begin
      r.dest_addr = dest_pool[$urandom_range(5)];
      r.gateway_addr = gate_pool[$urandom_range(3)];
    end
    case ($urandom_range(7))
      0: r.route_metric = 16'h0000;
      1: r.route_metric = METRIC_NONE;
      2, 3: r.route_metric = 16'($urandom_range(3));
      default: r.route_metric = 16'($urandom_range(16'hFFFF));
    endcase
    return r;
  endfunction

  initial begin
    int burst_left;
    int add_pct;
    int gap;
    burst_left = 0;
    add_pct = 55;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue_route_op(OP_FIND, 32'h0000_0000, 32'h0000_0000, 16'h0000);
    issue_route_op(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    issue_route_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    issue_route_op(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000, METRIC_NONE);
    issue_route_op(OP_FIND, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
    issue_route_op(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
    issue_route_op(OP_FIND, 32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF);
    issue_route_op(OP_ADD, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
    issue_route_op(OP_FIND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000);
    issue_route_op(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, 16'h0000);
    for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
      issue_route_op(OP_ADD, 32'h0000_1000 + i, ~(32'h0000_1000 + i), 16'(i));
    end
    issue_route_op(OP_ADD, 32'h0000_0000, 32'h0000_0000, 16'h0000);
    drain_responses();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(2))
          0: add_pct = 35;
          1: add_pct = 55;
          default: add_pct = 80;
        endcase
      end
      if (n == RANDOM_ITEMS / 2) drain_responses();
      if (burst_left == 0) begin
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
        if (gap > 0) pause_sender(gap);
        burst_left = $urandom_range(1, 12);
      end
      send_request(random_request(add_pct));
      burst_left--;
    end

    drain_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rtbm_pkg.sv
hw/rtl/rtbm_datapath.sv
hw/rtl/rtbm_ctrl.sv
hw/rtl/route_table_best_metric.sv
test/tb_top.sv
